FILE: rtl/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants for the interval timer with prescaler.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int ACTION_W    = 2;
	localparam int VALUE_W     = 8;
	localparam int SEL_W       = 2;
	localparam int PRESCALE_W  = 11;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK        = 2'd0,
		ACT_READ_TIMER  = 2'd1,
		ACT_READ_STATUS = 2'd2,
		ACT_WRITE       = 2'd3
	} action_t;

	typedef enum logic [SEL_W-1:0] {
		DIV_1    = 2'd0,
		DIV_8    = 2'd1,
		DIV_64   = 2'd2,
		DIV_1024 = 2'd3
	} interval_t;

	localparam logic [VALUE_W-1:0]    TIMER_RESET    = 8'hFF;
	localparam logic [PRESCALE_W-1:0] PRESCALE_ONE   = 11'd1;
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 11'd1024;

	function automatic logic [PRESCALE_W-1:0] interval_ticks(input interval_t code);
		logic [PRESCALE_W-1:0] ticks;
		unique case (code)
			DIV_1:    ticks = 11'd1;
			DIV_8:    ticks = 11'd8;
			DIV_64:   ticks = 11'd64;
			DIV_1024: ticks = 11'd1024;
			default:  ticks = 11'd1024;
		endcase
		return ticks;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/interval_timer_with_prescaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_timer_with_prescaler
// 8-bit down-counting interval timer behind a 1/8/64/1024 prescaler.
// ----------------------------------------------------------------------------
// Each request is one action (tick, timer read, status read, write) and
// returns exactly one response byte. A request is captured in an input
// register; as it leaves that register the timer state is updated and the
// response is registered, and a new request is taken every cycle while the
// response side keeps up. Throughput is set by the single state update
// path; a stalled response holds the input register and then deasserts
// s_axis_tready.
module interval_timer_with_prescaler (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// [7:0] write_value, [9:8] interval_select, [15:10] zero
	input  wire logic [itp_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// [1:0] action
	input  wire logic [itp_pkg::ACTION_W-1:0]  s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// [7:0] read_data
	output logic [itp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import itp_pkg::*;

	logic                  valid_s1;
	action_t               action_s1;
	logic [VALUE_W-1:0]    value_s1;
	interval_t             sel_s1;
	logic                  advance;

	logic [VALUE_W-1:0]    timer_q, timer_d;
	logic [PRESCALE_W-1:0] prescale_q, prescale_d;
	interval_t             interval_q, interval_d;
	logic                  flag_high_q, flag_high_d;
	logic                  flag_low_q, flag_low_d;
	logic [VALUE_W-1:0]    result_d;
	logic [VALUE_W-1:0]    timer_dec;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= action_t'(s_axis_tuser);
			value_s1  <= s_axis_tdata[VALUE_W-1:0];
			sel_s1    <= interval_t'(s_axis_tdata[VALUE_W+SEL_W-1:VALUE_W]);
		end
	end

	assign timer_dec = timer_q - 8'd1;

	always_comb begin
		timer_d     = timer_q;
		prescale_d  = prescale_q;
		interval_d  = interval_q;
		flag_high_d = flag_high_q;
		flag_low_d  = flag_low_q;
		result_d    = '0;
		unique case (action_s1)
			ACT_TICK: begin
				if (prescale_q > PRESCALE_ONE) begin
					prescale_d = prescale_q - PRESCALE_ONE;
				end else begin
					timer_d = timer_dec;
					// wrap from zero sets both flags
					if (timer_q == '0) begin
						flag_high_d = 1'b1;
						flag_low_d  = 1'b1;
					end
					if (flag_high_d) begin
						prescale_d = PRESCALE_ONE;
					end else begin
						prescale_d = interval_ticks(interval_q);
					end
				end
			end
			ACT_READ_TIMER: begin
				result_d    = timer_q;
				flag_high_d = 1'b0;
			end
			ACT_READ_STATUS: begin
				result_d   = {flag_high_q, flag_low_q, 6'd0};
				flag_low_d = 1'b0;
			end
			ACT_WRITE: begin
				timer_d     = value_s1;
				interval_d  = sel_s1;
				prescale_d  = PRESCALE_ONE;
				flag_high_d = 1'b0;
			end
			default: begin
				result_d = '0;
			end
		endcase
	end

	// timer state, updated as each request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q     <= TIMER_RESET;
			prescale_q  <= PRESCALE_RESET;
			interval_q  <= DIV_1024;
			flag_high_q <= 1'b0;
			flag_low_q  <= 1'b0;
		end else if (valid_s1 && advance) begin
			timer_q     <= timer_d;
			prescale_q  <= prescale_d;
			interval_q  <= interval_d;
			flag_high_q <= flag_high_d;
			flag_low_q  <= flag_low_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= result_d;
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interval timer with prescaler.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream with random gaps, and responses are taken
// from the master stream under random backpressure. A behavioral copy of the
// timer state predicts every response byte and the responses are compared in
// order. Directed requests hit underflow, flag clearing and every interval,
// then random write/tick/read sequences run, including one full 1024 interval.
// ----------------------------------------------------------------------------
module tb_top;
	import itp_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 7;
	localparam int ITEM_TARGET  = 1650;
	localparam int LONG_STALL   = 150;
	localparam int DRAIN_CYCLES = 10;
	localparam int TIMEOUT_NS   = 5000000;
	localparam int PRINT_LIMIT  = 50;

	class timer_response_board;
		logic [VALUE_W-1:0]    timer_count;
		logic [PRESCALE_W-1:0] prescale_count;
		interval_t             div_code;
		bit                    flag_hi;
		bit                    flag_lo;
		logic [OUT_DATA_W-1:0] expected_bytes[$];
		int unsigned           mismatches;

		function new();
			timer_count    = TIMER_RESET;
			prescale_count = PRESCALE_RESET;
			div_code       = DIV_1024;
			flag_hi        = 1'b0;
			flag_lo        = 1'b0;
			mismatches     = 0;
		endfunction

		function logic [PRESCALE_W-1:0] ticks_per_count(interval_t code);
			case (code)
				DIV_1:   return 11'd1;
				DIV_8:   return 11'd8;
				DIV_64:  return 11'd64;
				default: return 11'd1024;
			endcase
		endfunction

		// advance the timer state by one request and queue its response byte
		function void note_request(action_t act, logic [VALUE_W-1:0] val, interval_t sel);
			logic [OUT_DATA_W-1:0] rd;
			rd = '0;
			case (act)
				ACT_TICK: begin
					if (prescale_count > 1) begin
						prescale_count--;
					end else begin
						timer_count--;
						if (timer_count == 8'hFF) begin
							flag_hi = 1'b1;
							flag_lo = 1'b1;
						end
						// after underflow the timer runs at full tick rate
						prescale_count = flag_hi ? PRESCALE_ONE : ticks_per_count(div_code);
					end
				end
				ACT_READ_TIMER: begin
					rd      = timer_count;
					flag_hi = 1'b0;
				end
				ACT_READ_STATUS: begin
					rd      = {flag_hi, flag_lo, 6'b0};
					flag_lo = 1'b0;
				end
				default: begin
					timer_count    = val;
					div_code       = sel;
					prescale_count = PRESCALE_ONE;
					flag_hi        = 1'b0;
				end
			endcase
			expected_bytes.push_back(rd);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_LIMIT)
				$display("mismatch at %0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task check_response(logic [OUT_DATA_W-1:0] got);
			logic [OUT_DATA_W-1:0] want;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("response %02h with no request pending", got));
				return;
			end
			want = expected_bytes.pop_front();
			if (got !== want)
				report_mismatch($sformatf("read_data %02h, expected %02h", got, want));
		endtask

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
	logic [ACTION_W-1:0]     s_axis_tuser  = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;

	timer_response_board board = new();
	int unsigned sent_requests = 0;
	bit          long_stall_req = 1'b0;
	bit          stall_active = 1'b0;

	interval_timer_with_prescaler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// [7:0] write_value, [9:8] interval_select, [15:10] zero
		.s_axis_tdata  (s_axis_tdata),
		// [1:0] action
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// [7:0] read_data
		.m_axis_tdata  (m_axis_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_request(input action_t act, input logic [VALUE_W-1:0] val,
			input interval_t sel, input bit no_gap);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {6'b0, sel, val};
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(act, val, sel);
		sent_requests++;
		gap = no_gap ? 0 : idle_cycles();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// request without a payload, fields filled with noise
	task automatic send_read(input action_t act, input bit no_gap);
		send_request(act, VALUE_W'($urandom_range(0, 255)),
			interval_t'($urandom_range(0, 3)), no_gap);
	endtask

	function automatic action_t pick_body_action();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 78)
			return ACT_TICK;
		else if (r < 89)
			return ACT_READ_TIMER;
		else
			return ACT_READ_STATUS;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_response(m_axis_tdata);
	end

	// response side backpressure
	initial begin : rx_side
		int unsigned run;
		int unsigned gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_active   = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				stall_active = 1'b0;
			end else begin
				run = $urandom_range(1, 30);
				m_axis_tready <= 1'b1;
				repeat (run) @(posedge clk);
				gap = idle_cycles();
				if (gap != 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin : timeout_guard
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int unsigned       r;
		int unsigned       len;
		int unsigned       k;
		bit                burst;
		bit                held_off;
		bit                drained;
		bit                long_run_done;
		logic [VALUE_W-1:0] val;
		interval_t         sel;

		held_off      = 1'b0;
		drained       = 1'b0;
		long_run_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values
		send_read(ACT_READ_TIMER, 1'b0);
		send_read(ACT_READ_STATUS, 1'b0);
		// underflow from zero at full rate sets both flags
		send_request(ACT_WRITE, 8'h00, DIV_1, 1'b0);
		send_read(ACT_TICK, 1'b0);
		send_read(ACT_READ_STATUS, 1'b0);
		send_read(ACT_READ_STATUS, 1'b0);
		// high flag keeps the timer counting every tick
		send_read(ACT_TICK, 1'b0);
		send_read(ACT_READ_TIMER, 1'b0);
		send_read(ACT_READ_STATUS, 1'b0);
		// top value, divide by eight
		send_request(ACT_WRITE, 8'hFF, DIV_8, 1'b0);
		for (k = 0; k < 9; k++)
			send_read(ACT_TICK, 1'b0);
		send_read(ACT_READ_TIMER, 1'b0);
		// a write clears the high flag but keeps the low one
		send_request(ACT_WRITE, 8'h00, DIV_64, 1'b0);
		send_read(ACT_TICK, 1'b0);
		send_request(ACT_WRITE, 8'h55, DIV_1024, 1'b0);
		send_read(ACT_READ_STATUS, 1'b0);
		send_read(ACT_READ_TIMER, 1'b0);

		while (sent_requests < ITEM_TARGET) begin
			if (!held_off && sent_requests >= 700) begin
				held_off = 1'b1;
				s_axis_tvalid <= 1'b0;
				long_stall_req = 1'b1;
				while (!stall_active) @(posedge clk);
				// keep offering while responses are blocked
				for (k = 0; k < 30; k++)
					send_read(pick_body_action(), 1'b1);
			end
			if (!drained && sent_requests >= 1200) begin
				drained = 1'b1;
				s_axis_tvalid <= 1'b0;
				while (board.pending() != 0) @(posedge clk);
			end

			burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (!long_run_done && sent_requests >= 300) begin
				// one full 1024 interval down through underflow
				long_run_done = 1'b1;
				send_request(ACT_WRITE, 8'h01, DIV_1024, burst);
				for (k = 0; k < 1025; k++) begin
					send_read(ACT_TICK, burst);
					if ((k % 128) == 127)
						send_read(ACT_READ_TIMER, burst);
				end
				send_read(ACT_READ_STATUS, burst);
				send_read(ACT_READ_TIMER, burst);
			end else if (r < 10) begin
				// unstructured requests
				for (k = 0; k < 8; k++)
					send_request(action_t'($urandom_range(0, 3)),
						VALUE_W'($urandom_range(0, 255)),
						interval_t'($urandom_range(0, 3)), burst);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					sel = DIV_1;
				else if (r < 75)
					sel = DIV_8;
				else if (r < 97)
					sel = DIV_64;
				else
					sel = DIV_1024;
				val = ($urandom_range(0, 99) < 55) ? VALUE_W'($urandom_range(0, 3))
					: VALUE_W'($urandom_range(0, 255));
				send_request(ACT_WRITE, val, sel, burst);
				len = $urandom_range(4, 40);
				for (k = 0; k < len; k++)
					send_read(pick_body_action(), burst);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
rtl/itp_pkg.sv
rtl/interval_timer_with_prescaler.sv
tb/sv/tb_top.sv
